### design/mec_pkg.sv
package mec_pkg;

  localparam int FX_W              = 48;
  localparam int HALF_W            = FX_W / 2;
  localparam int WIDE_W            = 52;
  localparam int PROD_W            = 2 * FX_W;
  localparam int COUNT_W           = 16;
  localparam int FRACTION_BITS_DEF = 32;
  localparam int unsigned ITER_LIMIT_DEF = 65535;
  localparam int QUEUE_DEPTH_DEF   = 2;

  typedef logic signed [FX_W-1:0]   fx_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(FX_W-1){1'b0}}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    fx_t  c_real;
    fx_t  c_imag;
    fx_t  z_real;
    fx_t  z_imag;
    logic hit;
  } item_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_START_A,
    FR_WAIT_A,
    FR_SUM,
    FR_START_B,
    FR_WAIT_B,
    FR_CLASS,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_START,
    BK_WAIT,
    BK_UPDATE,
    BK_CYCLE,
    BK_FINISH
  } back_state_t;

  function automatic wide_t widen(input fx_t v);
    return wide_t'(v);
  endfunction

  function automatic fx_t sat_wide(input wide_t v);
    if (v > wide_t'(FX_MAX)) return FX_MAX;
    if (v < wide_t'(FX_MIN)) return FX_MIN;
    return v[FX_W-1:0];
  endfunction

  function automatic fx_t sat_prod(input prod_t v);
    if (v > prod_t'(FX_MAX)) return FX_MAX;
    if (v < prod_t'(FX_MIN)) return FX_MIN;
    return v[FX_W-1:0];
  endfunction

endpackage

### design/mec_mul.sv
module mec_mul
  import mec_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  fx_t  a,
  input  fx_t  b,
  output logic done,
  output fx_t  prod
);

  fx_t                      a_q;
  fx_t                      b_q;
  prod_t                    acc;
  logic [1:0]               step;
  logic                     busy;
  logic                     fin;
  logic signed [HALF_W:0]   op_a;
  logic signed [HALF_W:0]   op_b;
  logic signed [FX_W+1:0]   pp;
  logic [$clog2(FX_W+1)-1:0] shift;
  prod_t                    pp_ext;

  // Four signed partial products of the operand halves, one per cycle.
  always_comb begin
    op_a = step[1] ? {a_q[FX_W-1], a_q[FX_W-1:HALF_W]} : {1'b0, a_q[HALF_W-1:0]};
    op_b = step[0] ? {b_q[FX_W-1], b_q[FX_W-1:HALF_W]} : {1'b0, b_q[HALF_W-1:0]};
    pp   = op_a * op_b;
    case (step)
      2'd0:    shift = '0;
      2'd3:    shift = ($clog2(FX_W+1))'(FX_W);
      default: shift = ($clog2(FX_W+1))'(HALF_W);
    endcase
    pp_ext = prod_t'(pp) <<< shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + pp_ext;
    end
    if (fin) begin
      prod <= sat_prod(acc >>> FRACTION_BITS);
    end
  end

  a_mul_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##6 done)
    else $error("Product not ready six cycles after start.");

endmodule

### design/mec_front.sv
module mec_front
  import mec_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  fx_t   c_real,
  input  fx_t   c_imag,
  input  fx_t   z_start_real,
  input  fx_t   z_start_imag,
  output logic  push,
  output item_t push_item,
  input  logic  full
);

  localparam fx_t FX_ONE    = fx_t'(64'd1 << FRACTION_BITS);
  localparam fx_t QUARTER   = FX_ONE >>> 2;
  localparam fx_t SIXTEENTH = FX_ONE >>> 4;
  localparam fx_t NEG_ONE   = -FX_ONE;
  localparam fx_t NEG_TWO   = -(FX_ONE <<< 1);

  front_state_t state;
  front_state_t state_next;

  fx_t  cr;
  fx_t  ci;
  fx_t  zr;
  fx_t  zi;
  fx_t  rm;
  fx_t  rp;
  fx_t  t;
  fx_t  i2;
  logic needle;
  logic hit;

  logic mul_start;
  logic mul_done;
  fx_t  mul0_a;
  fx_t  mul0_b;
  fx_t  mul1_a;
  fx_t  mul1_b;
  fx_t  mul0_prod;
  fx_t  mul1_prod;
  fx_t  tp;
  fx_t  card;
  fx_t  disc;

  always_comb begin
    tp   = sat_wide(widen(t) + widen(rm));
    card = sat_wide(widen(mul0_prod) <<< 2);
    disc = sat_wide(widen(mul1_prod) + widen(i2));
    if (state == FR_START_A) begin
      mul0_a = ci;
      mul0_b = ci;
      mul1_a = rm;
      mul1_b = rm;
    end else begin
      mul0_a = t;
      mul0_b = tp;
      mul1_a = rp;
      mul1_b = rp;
    end
  end

  mec_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul0 (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul0_a),
    .b     (mul0_b),
    .done  (mul_done),
    .prod  (mul0_prod)
  );

  mec_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul1 (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul1_a),
    .b     (mul1_b),
    .done  (),
    .prod  (mul1_prod)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE:    if (in_valid) state_next = FR_START_A;
      FR_START_A: state_next = FR_WAIT_A;
      FR_WAIT_A:  if (mul_done) state_next = FR_SUM;
      FR_SUM:     state_next = FR_START_B;
      FR_START_B: state_next = FR_WAIT_B;
      FR_WAIT_B:  if (mul_done) state_next = FR_CLASS;
      FR_CLASS:   state_next = FR_PUSH;
      FR_PUSH:    if (!full) state_next = FR_IDLE;
      default:    state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != FR_IDLE);
    mul_start = (state == FR_START_A) || (state == FR_START_B);
    push      = (state == FR_PUSH) && !full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      FR_IDLE: begin
        if (in_valid) begin
          cr     <= c_real;
          ci     <= c_imag;
          zr     <= z_start_real;
          zi     <= z_start_imag;
          rm     <= sat_wide(widen(c_real) - widen(QUARTER));
          rp     <= sat_wide(widen(c_real) + widen(FX_ONE));
          needle <= (c_imag == '0) && (c_real < NEG_ONE) && (c_real > NEG_TWO);
        end
      end
      FR_SUM: begin
        i2 <= mul0_prod;
        t  <= sat_wide(widen(mul1_prod) + widen(mul0_prod));
      end
      FR_CLASS: begin
        hit <= (card < i2) || (disc < SIXTEENTH) || needle;
      end
      default: ;
    endcase
  end

  assign push_item.c_real = cr;
  assign push_item.c_imag = ci;
  assign push_item.z_real = zr;
  assign push_item.z_imag = zi;
  assign push_item.hit    = hit;

endmodule

### design/mec_queue.sv
module mec_queue
  import mec_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head,
  output logic  empty
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full  = (fill == FILL_W'(DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + FILL_W'(1)))
    else $error("Queue fill level did not follow a lone push.");

endmodule

### design/mec_back.sv
module mec_back
  import mec_pkg::*;
#(
  parameter int          FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int unsigned ITER_LIMIT    = ITER_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  output logic               pop,
  input  logic               queue_empty,
  input  item_t              head,
  input  logic [FX_W-1:0]    radius,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               in_set,
  output logic [COUNT_W-1:0] escape_count,
  output fx_t                final_real,
  output fx_t                final_imag
);

  localparam int CNT_W = $clog2(64'(ITER_LIMIT) + 64'd1);
  localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  back_state_t state;
  back_state_t state_next;

  fx_t            cr;
  fx_t            ci;
  fx_t            zr;
  fx_t            zi;
  fx_t            sr;
  fx_t            si;
  logic           snap_valid;
  logic [CNT_W:0] deadline;
  logic [CNT_W-1:0] n;
  logic           res_in_set;

  logic mul_start;
  logic mul_done;
  fx_t  rr;
  fx_t  ii;
  fx_t  ri;
  fx_t  mag;
  fx_t  nr;
  fx_t  ni;
  logic escape;
  logic at_limit;
  logic cycle_hit;
  logic load_out;
  logic [CW-1:0]      n_wide;
  logic [COUNT_W-1:0] count_sat;

  mec_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_rr (
    .clk (clk), .rst (rst), .start (mul_start), .a (zr), .b (zr),
    .done (mul_done), .prod (rr)
  );

  mec_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_ii (
    .clk (clk), .rst (rst), .start (mul_start), .a (zi), .b (zi),
    .done (), .prod (ii)
  );

  mec_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_ri (
    .clk (clk), .rst (rst), .start (mul_start), .a (zr), .b (zi),
    .done (), .prod (ri)
  );

  always_comb begin
    mag       = sat_wide(widen(rr) + widen(ii));
    nr        = sat_wide(widen(rr) - widen(ii) + widen(cr));
    ni        = sat_wide((widen(ri) <<< 1) + widen(ci));
    escape    = $unsigned(mag) > radius;
    at_limit  = (n == CNT_W'(ITER_LIMIT));
    cycle_hit = snap_valid && (zr == sr) && (zi == si);
    n_wide    = CW'(n);
    count_sat = (n_wide > CW'(COUNT_MAX)) ? COUNT_MAX : n_wide[COUNT_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (!queue_empty) state_next = head.hit ? BK_FINISH : BK_START;
      BK_START:  state_next = at_limit ? BK_FINISH : BK_WAIT;
      BK_WAIT:   if (mul_done) state_next = BK_UPDATE;
      BK_UPDATE: state_next = escape ? BK_FINISH : BK_CYCLE;
      BK_CYCLE:  state_next = cycle_hit ? BK_FINISH : BK_START;
      BK_FINISH: if (!out_valid || !out_stall) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == BK_IDLE) && !queue_empty;
    mul_start = (state == BK_START) && !at_limit;
    load_out  = (state == BK_FINISH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      out_valid  <= 1'b0;
      snap_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        snap_valid <= 1'b0;
      end else if ((state == BK_CYCLE) && !cycle_hit && ({1'b0, n} == deadline)) begin
        snap_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (!queue_empty) begin
          cr         <= head.c_real;
          ci         <= head.c_imag;
          zr         <= head.z_real;
          zi         <= head.z_imag;
          n          <= '0;
          deadline   <= (CNT_W+1)'(1);
          res_in_set <= head.hit;
        end
      end
      BK_UPDATE: begin
        if (!escape) begin
          zr <= nr;
          zi <= ni;
        end
      end
      BK_CYCLE: begin
        if (cycle_hit) begin
          res_in_set <= 1'b1;
        end else begin
          if ({1'b0, n} == deadline) begin
            sr       <= zr;
            si       <= zi;
            deadline <= deadline << 1;
          end
          n <= n + CNT_W'(1);
        end
      end
      default: ;
    endcase
    if (load_out) begin
      in_set       <= res_in_set;
      escape_count <= res_in_set ? '0 : count_sat;
      final_real   <= res_in_set ? '0 : zr;
      final_imag   <= res_in_set ? '0 : zi;
    end
  end

  a_inside_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_set) |-> (escape_count == '0 && final_real == '0 && final_imag == '0))
    else $error("Point inside the set reported with a non-zero count or value.");

  a_below_limit: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CYCLE) |-> (n < CNT_W'(ITER_LIMIT)))
    else $error("Iteration carried on past the limit.");

endmodule

### design/mandelbrot_escape_count_top.sv
// Escape-time evaluation of Mandelbrot points in signed Q16.32 fixed point.
// The input channel (in_valid, in_stall) takes one transaction per point: c and
// the start value of z. The output channel (out_valid, out_stall) returns one
// transaction per point, in order: in_set, escape_count and the final z.
// The configuration channel (cfg_valid, cfg_ready) writes the squared escape
// radius; it is always ready and should be used only while the block is idle.
// The front end runs the cardioid, period-2 disc and needle tests and hands the
// point to a short queue. Each iteration of the engine uses the four-step
// partial-product multipliers. The result of a point caught by the region tests
// goes to the output without any iteration.
// The front end accepts a new point as soon as it has handed the previous one
// to the queue, so region tests overlap the iterations of earlier points.
// When the receiver stalls, the result is held in the output register, the
// engine waits with its next result, and the queue and then the input channel
// fill up and stall in turn. Reset empties the queue, drops any pending
// result and sets the escape radius squared to 16.0.
module mandelbrot_escape_count_top
  import mec_pkg::*;
#(
  parameter int          FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int unsigned ITER_LIMIT    = ITER_LIMIT_DEF,
  parameter int          QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [FX_W-1:0]    escape_radius_squared,
  input  logic               in_valid,
  output logic               in_stall,
  input  fx_t                c_real,
  input  fx_t                c_imag,
  input  fx_t                z_start_real,
  input  fx_t                z_start_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               in_set,
  output logic [COUNT_W-1:0] escape_count,
  output fx_t                final_real,
  output fx_t                final_imag
);

  localparam logic [FX_W-1:0] RADIUS_RESET = FX_W'(64'd16 << FRACTION_BITS);

  logic [FX_W-1:0] radius;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  item_t           push_item;
  item_t           head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius <= escape_radius_squared;
    end
  end

  mec_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .c_real       (c_real),
    .c_imag       (c_imag),
    .z_start_real (z_start_real),
    .z_start_imag (z_start_imag),
    .push         (push),
    .push_item    (push_item),
    .full         (full)
  );

  mec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  mec_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .ITER_LIMIT    (ITER_LIMIT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop          (pop),
    .queue_empty  (empty),
    .head         (head),
    .radius       (radius),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .in_set       (in_set),
    .escape_count (escape_count),
    .final_real   (final_real),
    .final_imag   (final_imag)
  );

endmodule
